// File: hw/rtl/pfrt_pkg.sv
`default_nettype none
package pfrt_pkg;

  localparam int unsigned FramesDef    = 32;
  localparam int unsigned PidBitsDef   = 8;
  localparam int unsigned PageBitsDef  = 20;
  localparam int unsigned StampBitsDef = 32;

  localparam int unsigned FrameOutBits = 5;
  localparam int unsigned UsedOutBits  = 6;
  localparam int unsigned CountBits    = 32;

  localparam logic ModeAccess   = 1'b0;
  localparam logic ModeSetDirty = 1'b1;
  localparam logic PolicyFifo   = 1'b0;
  localparam logic PolicyLru    = 1'b1;

  // update broadcast to the cells
  typedef enum logic [1:0] {
    OpNone,
    OpTouch,
    OpLoad,
    OpDirty
  } pfrt_op_e;

  // control part of the record that walks down the chain
  typedef struct packed {
    logic valid;
    logic match;
    logic free;
  } pfrt_carry_t;

endpackage
`default_nettype wire

// File: hw/rtl/pfrt_in_if.sv
`default_nettype none
interface pfrt_in_if #(
  parameter int unsigned PID_BITS  = 8,
  parameter int unsigned PAGE_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [PID_BITS-1:0]  pid;
  logic [PAGE_BITS-1:0] page;
  logic                 dirty_value;

  modport source (output valid, mode, pid, page, dirty_value, input ready);
  modport sink (input valid, mode, pid, page, dirty_value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pfrt_out_if.sv
`default_nettype none
interface pfrt_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [4:0]  frame;
  logic        replaced;
  logic        found;
  logic [31:0] hit_total;
  logic [31:0] fault_total;
  logic [5:0]  frames_in_use;

  modport source (output valid, hit, frame, replaced, found, hit_total, fault_total,
                  frames_in_use, input ready);
  modport sink (input valid, hit, frame, replaced, found, hit_total, fault_total,
                frames_in_use, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pfrt_cell.sv
`default_nettype none
module pfrt_cell
  import pfrt_pkg::*;
#(
  parameter int unsigned FRAMES     = FramesDef,
  parameter int unsigned PID_BITS   = PidBitsDef,
  parameter int unsigned PAGE_BITS  = PageBitsDef,
  parameter int unsigned STAMP_BITS = StampBitsDef,
  parameter int unsigned INDEX      = 0,
  localparam int unsigned IdxW      = $clog2(FRAMES)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  policy_i,
  input  wire logic [PID_BITS-1:0]   pid_i,
  input  wire logic [PAGE_BITS-1:0]  page_i,
  input  wire pfrt_carry_t           carry_i,
  input  wire logic [IdxW-1:0]       match_idx_i,
  input  wire logic [IdxW-1:0]       free_idx_i,
  input  wire logic [IdxW-1:0]       min_idx_i,
  input  wire logic [STAMP_BITS-1:0] min_stamp_i,
  output pfrt_carry_t                carry_o,
  output logic [IdxW-1:0]            match_idx_o,
  output logic [IdxW-1:0]            free_idx_o,
  output logic [IdxW-1:0]            min_idx_o,
  output logic [STAMP_BITS-1:0]      min_stamp_o,
  input  wire pfrt_op_e              op_i,
  input  wire logic [IdxW-1:0]       op_idx_i,
  input  wire logic [STAMP_BITS-1:0] op_stamp_i,
  input  wire logic                  op_dirty_i,
  output logic                       dirty_o
);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(INDEX);

  logic                  occ_q;
  logic                  dirty_q;
  logic [PID_BITS-1:0]   owner_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic [STAMP_BITS-1:0] load_q, use_q;
  logic [STAMP_BITS-1:0] own_stamp;
  logic                  is_match, take_min, sel;

  assign own_stamp = (policy_i == PolicyLru) ? use_q : load_q;
  assign is_match  = occ_q && (owner_q == pid_i) && (page_q == page_i);
  assign take_min  = (INDEX == 0) || (own_stamp < min_stamp_i);
  assign sel       = (op_idx_i == MyIdx);
  assign dirty_o   = dirty_q;

  // chain stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_o <= '0;
    end else begin
      carry_o.valid <= carry_i.valid;
      if (carry_i.valid) begin
        carry_o.match <= carry_i.match | is_match;
        carry_o.free  <= carry_i.free | ~occ_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (carry_i.valid) begin
      match_idx_o <= carry_i.match ? match_idx_i : MyIdx;
      free_idx_o  <= carry_i.free ? free_idx_i : MyIdx;
      if (take_min) begin
        min_idx_o   <= MyIdx;
        min_stamp_o <= own_stamp;
      end else begin
        min_idx_o   <= min_idx_i;
        min_stamp_o <= min_stamp_i;
      end
    end
  end

  // frame contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= 1'b0;
      dirty_q <= 1'b0;
    end else if (sel) begin
      if (op_i == OpLoad) begin
        occ_q   <= 1'b1;
        dirty_q <= 1'b0;
      end else if (op_i == OpDirty) begin
        dirty_q <= op_dirty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel) begin
      case (op_i)
        OpLoad: begin
          owner_q <= pid_i;
          page_q  <= page_i;
          load_q  <= op_stamp_i;
          use_q   <= op_stamp_i;
        end
        OpTouch: use_q <= op_stamp_i;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/page_frame_replacement_table_unit.sv
`default_nettype none
// fully associative page frame table with fifo or lru replacement
// req_i : one transaction per page access (mode 0) or set-dirty (mode 1)
// rsp_o : exactly one transaction per request: hit, frame, replaced, found,
//         saturating hit and fault totals and the occupied frame count
// policy_we_i / policy_i : victim policy register, 0 fifo, 1 lru (reset 1);
//         the user writes it only while no request is in flight; unchecked
// the frames sit in a row of cells; a search record is launched at cell 0
// and walks one cell per cycle, picking up the first match, the first free
// frame and the oldest stamp; the response register is loaded from the end
// of the chain as the block returns to idle, where it can take the next
// request; the walk along the chain sets the time per request and one
// request is handled at a time
// the response sits in an output register; a new request is taken while it
// waits, but the next response holds back until the receiver takes it
// reset frees all frames, clears tick and counters and selects lru
module page_frame_replacement_table_unit
  import pfrt_pkg::*;
#(
  parameter int unsigned FRAMES     = FramesDef,
  parameter int unsigned PID_BITS   = PidBitsDef,
  parameter int unsigned PAGE_BITS  = PageBitsDef,
  parameter int unsigned STAMP_BITS = StampBitsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   policy_we_i,
  input  wire logic   policy_i,
  pfrt_in_if.sink     req_i,
  pfrt_out_if.source  rsp_o
);
  localparam int unsigned IdxW  = $clog2(FRAMES);
  localparam int unsigned UsedW = $clog2(FRAMES + 1);

  typedef enum logic [1:0] {StIdle, StScan, StResp} state_e;

  state_e                state_q;
  logic                  policy_q;
  logic                  mode_q, dval_q, start_q;
  logic [PID_BITS-1:0]   pid_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic [STAMP_BITS-1:0] tick_q;
  logic [CountBits-1:0]  hits_q, faults_q;
  logic [UsedW-1:0]      used_q;
  pfrt_op_e              op_q;
  logic [IdxW-1:0]       op_idx_q;

  pfrt_carry_t           carry   [FRAMES+1];
  logic [IdxW-1:0]       m_idx   [FRAMES+1];
  logic [IdxW-1:0]       f_idx   [FRAMES+1];
  logic [IdxW-1:0]       n_idx   [FRAMES+1];
  logic [STAMP_BITS-1:0] n_stamp [FRAMES+1];
  logic [FRAMES-1:0]     dirty_bits;

  assign carry[0]   = '{valid: start_q, match: 1'b0, free: 1'b0};
  assign m_idx[0]   = '0;
  assign f_idx[0]   = '0;
  assign n_idx[0]   = '0;
  assign n_stamp[0] = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    pfrt_cell #(
      .FRAMES(FRAMES), .PID_BITS(PID_BITS), .PAGE_BITS(PAGE_BITS),
      .STAMP_BITS(STAMP_BITS), .INDEX(g)
    ) u_cell (
      .clk_i, .rst_ni,
      .policy_i    (policy_q),
      .pid_i       (pid_q),
      .page_i      (page_q),
      .carry_i     (carry[g]),
      .match_idx_i (m_idx[g]),
      .free_idx_i  (f_idx[g]),
      .min_idx_i   (n_idx[g]),
      .min_stamp_i (n_stamp[g]),
      .carry_o     (carry[g+1]),
      .match_idx_o (m_idx[g+1]),
      .free_idx_o  (f_idx[g+1]),
      .min_idx_o   (n_idx[g+1]),
      .min_stamp_o (n_stamp[g+1]),
      .op_i        (op_q),
      .op_idx_i    (op_idx_q),
      .op_stamp_i  (tick_q),
      .op_dirty_i  (dval_q),
      .dirty_o     (dirty_bits[g])
    );
  end

  // search outcome at the end of the chain
  logic            res_match, res_free, slot_free;
  logic [IdxW-1:0] victim;
  assign res_match = carry[FRAMES].match;
  assign res_free  = carry[FRAMES].free;
  assign victim    = res_free ? f_idx[FRAMES] : n_idx[FRAMES];
  assign slot_free = !rsp_o.valid || rsp_o.ready;

  assign req_i.ready = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      policy_q    <= PolicyLru;
      start_q     <= 1'b0;
      tick_q      <= '0;
      hits_q      <= '0;
      faults_q    <= '0;
      used_q      <= '0;
      op_q        <= OpNone;
      op_idx_q    <= '0;
      rsp_o.valid <= 1'b0;
    end else begin
      if (policy_we_i) policy_q <= policy_i;
      // launch the search record through start_q, registered at acceptance
      start_q <= (state_q == StIdle) && req_i.valid;
      // table update issued with the response, applied in the cycle after
      if (state_q == StResp && slot_free) begin
        if (mode_q == ModeSetDirty) begin
          op_q <= res_match ? OpDirty : OpNone;
        end else begin
          op_q <= res_match ? OpTouch : OpLoad;
        end
      end else begin
        op_q <= OpNone;
      end
      if (state_q == StResp && slot_free) begin
        rsp_o.valid <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_o.valid <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (req_i.valid) begin
            state_q <= StScan;
            // access advances the saturating tick up front
            if (req_i.mode == ModeAccess && tick_q != '1) tick_q <= tick_q + 1'b1;
          end
        end
        StScan: begin
          if (carry[FRAMES].valid) state_q <= StResp;
        end
        StResp: begin
          if (slot_free) begin
            state_q <= StIdle;
            if (mode_q == ModeSetDirty) begin
              if (res_match) begin
                op_idx_q <= m_idx[FRAMES];
              end
            end else if (res_match) begin
              op_idx_q <= m_idx[FRAMES];
              if (hits_q != '1) hits_q <= hits_q + 1'b1;
            end else begin
              op_idx_q <= victim;
              if (faults_q != '1) faults_q <= faults_q + 1'b1;
              if (res_free) used_q <= used_q + 1'b1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // request capture and response payload
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      mode_q <= req_i.mode;
      pid_q  <= req_i.pid;
      page_q <= req_i.page;
      dval_q <= req_i.dirty_value;
    end
    if (state_q == StResp && slot_free) begin
      rsp_o.hit      <= (mode_q == ModeAccess) && res_match;
      rsp_o.found    <= (mode_q == ModeSetDirty) && res_match;
      rsp_o.replaced <= (mode_q == ModeAccess) && !res_match && !res_free;
      if (res_match) begin
        rsp_o.frame <= FrameOutBits'(m_idx[FRAMES]);
      end else if (mode_q == ModeAccess) begin
        rsp_o.frame <= FrameOutBits'(victim);
      end else begin
        rsp_o.frame <= '0;
      end
      rsp_o.hit_total   <= (mode_q == ModeAccess && res_match && hits_q != '1)
                           ? hits_q + 1'b1 : hits_q;
      rsp_o.fault_total <= (mode_q == ModeAccess && !res_match && faults_q != '1)
                           ? faults_q + 1'b1 : faults_q;
      rsp_o.frames_in_use <= UsedOutBits'((mode_q == ModeAccess && !res_match && res_free)
                             ? used_q + 1'b1 : used_q);
    end
  end

  // dirty bits are kept per frame but not brought out of the block
  logic dirty_any;
  assign dirty_any = |dirty_bits;
  logic unused_dirty;
  assign unused_dirty = dirty_any;
endmodule
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
// page frame table testbench: directed and random accesses against a local
// model of the frame table, responses checked in order
module tb_top;
  import pfrt_pkg::*;

  localparam int unsigned NF = FramesDef;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic                   mode;
    logic [PidBitsDef-1:0]  pid;
    logic [PageBitsDef-1:0] page;
    logic                   dirty_value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [4:0]  frame;
    logic        replaced;
    logic        found;
    logic [31:0] hit_total;
    logic [31:0] fault_total;
    logic [5:0]  frames_in_use;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic policy_we_i = 1'b0;
  logic policy_i = 1'b0;

  pfrt_in_if #(.PID_BITS(PidBitsDef), .PAGE_BITS(PageBitsDef)) req_if ();
  pfrt_out_if rsp_if ();

  page_frame_replacement_table_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .policy_we_i (policy_we_i),
    .policy_i    (policy_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // frame table model
  logic [PidBitsDef-1:0]   tbl_owner [NF];
  logic [PageBitsDef-1:0]  tbl_page [NF];
  logic                    tbl_busy [NF];
  logic                    tbl_dirty [NF];
  logic [StampBitsDef-1:0] tbl_loaded [NF];
  logic [StampBitsDef-1:0] tbl_used [NF];
  logic [StampBitsDef-1:0] cur_tick;
  logic [31:0]             hits_seen, faults_seen;
  logic                    cur_policy;

  req_t pending_reqs[$];
  rsp_t awaited_rsps[$];
  int   fail_count = 0;
  int   idle_pct = 36;
  bit   stim_done = 1'b0;
  int   quiet_cycles = 0;

  function automatic void add_req(input req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic table_clear();
    for (int i = 0; i < NF; i++) begin
      tbl_owner[i] = '0; tbl_page[i] = '0; tbl_busy[i] = 1'b0;
      tbl_dirty[i] = 1'b0; tbl_loaded[i] = '0; tbl_used[i] = '0;
    end
    cur_tick = '0; hits_seen = '0; faults_seen = '0; cur_policy = PolicyLru;
  endtask

  // works out the response of one request and updates the model table
  function automatic rsp_t lookup_frame(input req_t r);
    rsp_t o;
    int m, v;
    int cnt;
    o = '0; m = -1; v = -1; cnt = 0;
    for (int i = 0; i < NF; i++)
      if (m < 0 && tbl_busy[i] && tbl_owner[i] == r.pid && tbl_page[i] == r.page) m = i;
    if (r.mode == ModeSetDirty) begin
      if (m >= 0) begin
        tbl_dirty[m] = r.dirty_value; o.found = 1'b1; o.frame = m[4:0];
      end
    end else begin
      if (cur_tick != '1) cur_tick++;
      if (m >= 0) begin
        o.hit = 1'b1; o.frame = m[4:0]; tbl_used[m] = cur_tick;
        if (hits_seen != '1) hits_seen++;
      end else begin
        if (faults_seen != '1) faults_seen++;
        for (int i = 0; i < NF; i++)
          if (v < 0 && !tbl_busy[i]) v = i;
        if (v < 0) begin
          // oldest stamp wins, lowest index on a tie
          v = 0;
          for (int i = 1; i < NF; i++)
            if (cur_policy == PolicyLru ? tbl_used[i] < tbl_used[v]
                                        : tbl_loaded[i] < tbl_loaded[v]) v = i;
          o.replaced = 1'b1;
        end
        tbl_owner[v] = r.pid; tbl_page[v] = r.page; tbl_busy[v] = 1'b1;
        tbl_dirty[v] = 1'b0; tbl_loaded[v] = cur_tick; tbl_used[v] = cur_tick;
        o.frame = v[4:0];
      end
    end
    for (int i = 0; i < NF; i++) if (tbl_busy[i]) cnt++;
    o.hit_total = hits_seen; o.fault_total = faults_seen; o.frames_in_use = cnt[5:0];
    return o;
  endfunction

  // driver: presents the next pending request, idles at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.mode <= ModeAccess; req_if.pid <= '0; req_if.page <= '0;
      req_if.dirty_value <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_rsps.insert(awaited_rsps.size(), lookup_frame(pending_reqs.pop_front()));
      end
      if ((!req_if.valid || req_if.ready) ) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          req_if.valid <= 1'b1;
          {req_if.mode, req_if.pid, req_if.page, req_if.dirty_value} <= pending_reqs[0];
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stalls at random, checks every response transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_t want;
        if (awaited_rsps.size() == 0) begin
          report("unexpected response", 0, 0);
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp_if.hit !== want.hit) report("hit", rsp_if.hit, want.hit);
          if (rsp_if.frame !== want.frame) report("frame", rsp_if.frame, want.frame);
          if (rsp_if.replaced !== want.replaced)
            report("replaced", rsp_if.replaced, want.replaced);
          if (rsp_if.found !== want.found) report("found", rsp_if.found, want.found);
          if (rsp_if.hit_total !== want.hit_total)
            report("hit_total", rsp_if.hit_total, want.hit_total);
          if (rsp_if.fault_total !== want.fault_total)
            report("fault_total", rsp_if.fault_total, want.fault_total);
          if (rsp_if.frames_in_use !== want.frames_in_use)
            report("frames_in_use", rsp_if.frames_in_use, want.frames_in_use);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
    else if (rst_ni && !stim_done) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic req_t make_req(input logic mode, input logic [PidBitsDef-1:0] pid,
                                    input logic [PageBitsDef-1:0] page, input logic dv);
    req_t r;
    r.mode = mode; r.pid = pid; r.page = page; r.dirty_value = dv;
    return r;
  endfunction

  // waits until the block is idle with nothing in flight
  task automatic drain();
    while (pending_reqs.size() > 0 || awaited_rsps.size() > 0) @(posedge clk_i);
    repeat (NF + 8) @(posedge clk_i);
  endtask

  task automatic write_policy(input logic p);
    @(posedge clk_i);
    policy_we_i <= 1'b1; policy_i <= p;
    @(posedge clk_i);
    policy_we_i <= 1'b0;
    cur_policy = p;
  endtask

  // mostly a small working set so that hits, fills and evictions all occur
  task automatic random_burst(input int n, input int pool);
    logic [PidBitsDef-1:0] pid;
    logic [PageBitsDef-1:0] page;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        pid = PidBitsDef'($urandom); page = PageBitsDef'($urandom);
      end else begin
        pid = PidBitsDef'($urandom_range(3) * 85);
        page = PageBitsDef'($urandom_range(pool - 1) * 32'h0_8421);
      end
      add_req(make_req($urandom_range(4) == 0, pid, page, 1'($urandom_range(1))));
    end
  endtask

  initial begin
    table_clear();
    req_if.valid = 1'b0;
    rsp_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: set-dirty on empty table, field extremes, hit, fill
    add_req(make_req(ModeSetDirty, 8'hff, 20'hfffff, 1'b1));
    add_req(make_req(ModeAccess, 8'h00, 20'h00000, 1'b0));
    add_req(make_req(ModeAccess, 8'hff, 20'hfffff, 1'b1));
    add_req(make_req(ModeAccess, 8'h00, 20'h00000, 1'b0));
    add_req(make_req(ModeSetDirty, 8'hff, 20'hfffff, 1'b1));
    add_req(make_req(ModeSetDirty, 8'hff, 20'hfffff, 1'b0));
    add_req(make_req(ModeAccess, 8'h00, 20'hfffff, 1'b0));
    for (int i = 0; i < 18; i++)
      add_req(make_req(ModeAccess, 8'h5a, PageBitsDef'(i), 1'b0));
    drain();

    // no random idling on either side for this burst
    idle_pct = 0;
    random_burst(150, 40);
    drain();
    idle_pct = 36;
    write_policy(PolicyFifo);
    random_burst(400, 48);
    drain();
    write_policy(PolicyLru);
    random_burst(400, 40);
    drain();
    write_policy(PolicyFifo);
    random_burst(350, 36);
    drain();
    stim_done = 1'b1;

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
